// File: src/wpf_pkg.sv
// ============================================================================
// wpf_pkg
// Shared types and constants of the waypoint follower step core.
// ============================================================================
package wpf_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 32;
  localparam int CFG_W    = 16;
  localparam int REMAIN_W = 7;

  // Default queue depth.
  localparam int PATH_DEPTH_DEF = 64;

  // Register reset values: 0.02 m in Q16.16.
  localparam logic [CFG_W-1:0] STEP_LENGTH_RST  = 16'd1311;
  localparam logic [CFG_W-1:0] REACH_RADIUS_RST = 16'd1311;

  // Configuration register indexes.
  localparam logic CFG_STEP_LENGTH  = 1'b0;
  localparam logic CFG_REACH_RADIUS = 1'b1;

  // Item operations.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Iteration counts of the shared sequencer.
  localparam int ITER_W     = 5;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQ_X,
    S_SQ_Y,
    S_ROOT_INIT,
    S_ROOT,
    S_CHECK,
    S_DIV_INIT,
    S_DIV,
    S_DIV_END,
    S_OUT
  } state_t;

  // Adds a signed step of magnitude q to a coordinate, saturating to 32 bits.
  function automatic logic signed [COORD_W-1:0] sat_step(
    input logic signed [COORD_W-1:0] base,
    input logic                      neg,
    input logic        [CFG_W-1:0]   q
  );
    logic signed [COORD_W:0] delta;
    logic signed [COORD_W:0] sum;
    delta = $signed({{(COORD_W-CFG_W+1){1'b0}}, q});
    if (neg) begin
      delta = -delta;
    end
    sum = $signed({base[COORD_W-1], base}) + delta;
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      sat_step = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_step = sum[COORD_W-1:0];
    end
  endfunction

endpackage

// File: src/wpf_ram.sv
// ============================================================================
// wpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module wpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/waypoint_follow_step_core.sv
// ============================================================================
// waypoint_follow_step_core
// Constant-speed waypoint follower: a Q16.16 robot position chases the head
// of a circular waypoint queue by one step length per tick.
// ============================================================================
// Usage. Items arrive on the input channel (in_valid / in_stall); a transfer
// happens on a clock edge with in_valid high and in_stall low. A load item
// (op = 1) appends a waypoint; loads stream at one per cycle while no tick
// is in work. A tick item (op = 0) yields exactly one result on the output
// channel (out_valid / out_stall): the position before the tick, whether the
// head waypoint was popped, and how many waypoints remain.
// A tick on an empty queue goes straight to the result state, a tick that
// pops the head ends after the root and the reach check, and a tick that
// moves the robot also runs both divides. One shared subtractor builds the
// 32-bit square root one bit per cycle and then two 16-bit quotients one bit
// per cycle; a single shared 32x32 multiplier forms the squares and the step products.
// in_stall stays high while a tick is in work. The result sits in an output
// register, so a new item is taken while a result still waits; a tick that
// finishes while the receiver stalls holds in its last state until the
// register frees up. Reset (rst, synchronous) zeroes position, head and
// count, and restores both registers to 0.02 m. The waypoint memory is not
// cleared; only entries that were written are ever read.
// ============================================================================
module waypoint_follow_step_core #(
  parameter int PATH_DEPTH = wpf_pkg::PATH_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic        [wpf_pkg::CFG_W-1:0]    cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic                                path_start,
  input  logic signed [wpf_pkg::COORD_W-1:0]  waypoint_x,
  input  logic signed [wpf_pkg::COORD_W-1:0]  waypoint_y,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wpf_pkg::COORD_W-1:0]  pos_x,
  output logic signed [wpf_pkg::COORD_W-1:0]  pos_y,
  output logic                                waypoint_reached,
  output logic        [wpf_pkg::REMAIN_W-1:0] remaining
);

  import wpf_pkg::*;

  localparam int IW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);
  localparam int SW = IW + 1;
  localparam int RW = (CW > REMAIN_W) ? CW : REMAIN_W;

  state_t state, state_next;

  // Registers and queue state.
  logic        [CFG_W-1:0]   step_length;
  logic        [CFG_W-1:0]   reach_radius;
  logic signed [COORD_W-1:0] robot_x;
  logic signed [COORD_W-1:0] robot_y;
  logic        [IW-1:0]      head;
  logic        [CW-1:0]      count;

  // Tick datapath.
  logic signed [COORD_W-1:0] rep_x;
  logic signed [COORD_W-1:0] rep_y;
  logic                      reached;
  logic [30:0]               ax;
  logic [30:0]               ay;
  logic                      neg_x;
  logic                      neg_y;
  logic                      scaled;
  logic [61:0]               prod;
  logic [61:0]               acc;
  logic [31:0]               root;
  logic [33:0]               rem;
  logic [63:0]               work;
  logic [ITER_W-1:0]         iter;
  logic                      div_y;

  // Memory ports.
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [2*COORD_W-1:0]      ram_rdata;

  // Load path.
  logic                      in_fire;
  logic                      load_fire;
  logic                      tick_fire;
  logic [IW-1:0]             head_eff;
  logic [CW-1:0]             count_eff;
  logic [SW-1:0]             slot_sum;

  // Difference stage.
  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W:0]          dxa;
  logic [COORD_W:0]          dya;
  logic                      big;

  // Shared multiplier and subtractor.
  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic [63:0]               mul_p;
  logic [35:0]               sub_a;
  logic [35:0]               sub_b;
  logic [36:0]               sub_d;
  logic                      sub_ge;

  logic [47:0]               numer;
  logic                      pop;
  logic                      out_free;
  logic [IW-1:0]             head_inc;
  logic [RW-1:0]             count_wide;

  wpf_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (PATH_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({waypoint_x, waypoint_y}),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (op == OP_LOAD);
  assign tick_fire = in_fire && (op == OP_TICK);

  // A path start empties the queue before the append.
  assign head_eff  = path_start ? '0 : head;
  assign count_eff = path_start ? '0 : count;
  assign slot_sum  = SW'(head_eff) + SW'(count_eff);
  assign ram_waddr = (slot_sum >= SW'(PATH_DEPTH)) ? IW'(slot_sum - SW'(PATH_DEPTH))
                                                    : IW'(slot_sum);
  assign ram_we    = load_fire && (count_eff < CW'(PATH_DEPTH));

  assign head_inc  = (head == IW'(PATH_DEPTH - 1)) ? '0 : head + 1'b1;

  // Differences to the head waypoint, exact in 33 bits.
  assign dx  = $signed({ram_rdata[2*COORD_W-1], ram_rdata[2*COORD_W-1:COORD_W]})
             - $signed({robot_x[COORD_W-1], robot_x});
  assign dy  = $signed({ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]})
             - $signed({robot_y[COORD_W-1], robot_y});
  assign dxa = dx[COORD_W] ? 33'(-dx) : 33'(dx);
  assign dya = dy[COORD_W] ? 33'(-dy) : 33'(dy);
  assign big = dxa[31] || dya[31];

  // The multiplier serves both squares and both step products.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ_X: begin
        mul_a = {1'b0, ax};
        mul_b = {1'b0, ax};
      end
      S_SQ_Y: begin
        mul_a = {1'b0, ay};
        mul_b = {1'b0, ay};
      end
      S_CHECK: begin
        mul_a = 32'(step_length);
        mul_b = {1'b0, ax};
      end
      S_DIV_INIT: begin
        mul_a = 32'(step_length);
        mul_b = {1'b0, ay};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The subtractor does the trial step of the root and of the divide.
  always_comb begin
    if (state == S_ROOT) begin
      sub_a = {rem, work[63:62]};
      sub_b = {2'b00, root, 2'b01};
    end else begin
      sub_a = {3'b000, rem[31:0], work[15]};
      sub_b = {4'b0000, root};
    end
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_d[36];

  // Rounded quotient numerator: step * a + dist / 2.
  assign numer = 48'(prod) + 48'(root[31:1]);

  assign pop      = !scaled && (root < 32'(reach_radius));
  assign out_free = !out_valid || !out_stall;

  assign count_wide = RW'(count);

  // Sequencer.
  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (tick_fire) begin
          state_next = (count != '0) ? S_DIFF : S_OUT;
        end
      end
      S_DIFF:      state_next = S_SQ_X;
      S_SQ_X:      state_next = S_SQ_Y;
      S_SQ_Y:      state_next = S_ROOT_INIT;
      S_ROOT_INIT: state_next = S_ROOT;
      S_ROOT: begin
        if (iter == ITER_W'(ROOT_STEPS - 1)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pop || (root == '0)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT:  state_next = S_DIV;
      S_DIV: begin
        if (iter == ITER_W'(DIV_STEPS - 1)) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END:   state_next = div_y ? S_OUT : S_DIV_INIT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length  <= STEP_LENGTH_RST;
      reach_radius <= REACH_RADIUS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_LENGTH:  step_length  <= cfg_data;
        CFG_REACH_RADIUS: reach_radius <= cfg_data;
        default:          step_length  <= step_length;
      endcase
    end
  end

  // Queue pointers and robot position.
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      robot_x <= '0;
      robot_y <= '0;
      div_y   <= 1'b0;
    end else begin
      if (load_fire) begin
        head  <= head_eff;
        count <= ram_we ? count_eff + 1'b1 : count_eff;
      end
      if ((state == S_CHECK) && pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
      if (state == S_CHECK) begin
        div_y <= 1'b0;
      end
      if (state == S_DIV_END) begin
        div_y <= 1'b1;
        if (div_y) begin
          robot_y <= sat_step(robot_y, neg_y, work[15:0]);
        end else begin
          robot_x <= sat_step(robot_x, neg_x, work[15:0]);
        end
      end
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        rep_x   <= robot_x;
        rep_y   <= robot_y;
        reached <= 1'b0;
      end
      S_DIFF: begin
        // Halve both legs when either reaches 2^31 so the squares fit.
        ax     <= big ? dxa[31:1] : dxa[30:0];
        ay     <= big ? dya[31:1] : dya[30:0];
        neg_x  <= dx[COORD_W];
        neg_y  <= dy[COORD_W];
        scaled <= big;
      end
      S_SQ_X: begin
        prod <= mul_p[61:0];
      end
      S_SQ_Y: begin
        acc  <= prod;
        prod <= mul_p[61:0];
      end
      S_ROOT_INIT: begin
        work <= {1'b0, 63'(acc) + 63'(prod)};
        root <= '0;
        rem  <= '0;
        iter <= '0;
      end
      S_ROOT: begin
        rem  <= sub_ge ? sub_d[33:0] : sub_a[33:0];
        root <= {root[30:0], sub_ge};
        work <= {work[61:0], 2'b00};
        iter <= iter + 1'b1;
      end
      S_CHECK: begin
        if (pop) begin
          reached <= 1'b1;
        end
        prod <= mul_p[61:0];
      end
      S_DIV_INIT: begin
        // The quotient never exceeds step_length, so the top of the
        // numerator starts below the divisor.
        rem  <= {2'b00, numer[47:16]};
        work <= {48'b0, numer[15:0]};
        iter <= '0;
        if (!div_y) begin
          prod <= mul_p[61:0];
        end
      end
      S_DIV: begin
        // The partial remainder stays below the divisor, so 32 bits hold it.
        rem  <= sub_ge ? {2'b00, sub_d[31:0]} : {2'b00, sub_a[31:0]};
        work <= {48'b0, work[14:0], sub_ge};
        iter <= iter + 1'b1;
      end
      S_DIV_END: begin
        iter <= '0;
      end
      S_OUT: begin
        iter <= '0;
      end
      default: begin
        iter <= '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      pos_x            <= rep_x;
      pos_y            <= rep_y;
      waypoint_reached <= reached;
      remaining        <= count_wide[REMAIN_W-1:0];
    end
  end

  // The queue never holds more entries than the memory has.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(PATH_DEPTH))
    else $error("waypoint count exceeds queue depth");

  // A reached waypoint leaves the queue one entry shorter.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) && pop |=> (count + 1'b1) == $past(count))
    else $error("pop did not decrement the waypoint count");

  // A new result is only raised from the result state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the result state");

  // The head index stays inside the memory.
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= IW'(PATH_DEPTH - 1))
    else $error("head index out of range");

endmodule
